// ===== rtl/fixed_frame_receiver_with_fifo_macros.svh =====
// Assertion macros for the fixed frame receiver.
`ifndef FIXED_FRAME_RECEIVER_WITH_FIFO_MACROS_SVH
`define FIXED_FRAME_RECEIVER_WITH_FIFO_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FFRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FFRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffrf_pkg.sv =====
// Shared types and constants of the fixed frame receiver.
package ffrf_pkg;

  localparam int FRAME_LEN          = 16;
  localparam int DEFAULT_FIFO_DEPTH = 8;
  localparam int CFG_IDX_W          = 1;
  localparam int CFG_DATA_W         = 8;
  localparam int COUNT_OUT_W        = 4;

  localparam logic [CFG_IDX_W-1:0]  REG_START_DELIM = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_END_DELIM   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] START_DELIM_RST = 8'h2A;  // '*'
  localparam logic [CFG_DATA_W-1:0] END_DELIM_RST   = 8'h23;  // '#'

  localparam logic ACT_RX  = 1'b0;
  localparam logic ACT_POP = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_STORED  = 2'd1,
    EV_BAD     = 2'd2,
    EV_DROPPED = 2'd3
  } frame_event_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_OK    = 2'd1,
    ST_FULL  = 2'd2
  } fifo_status_t;

  // Assembler to top: frame completion this transfer.
  typedef struct packed {
    logic done;
    logic ok;
  } frame_stat_t;

  // FIFO to top: current occupancy flags and post-transfer figures.
  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [COUNT_OUT_W-1:0] count_nxt;
    fifo_status_t           status_nxt;
  } fifo_stat_t;

endpackage

// ===== rtl/ffrf_ifs.sv =====
// Valid/ready channel interfaces for the input and result streams.
interface ffrf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface ffrf_out_if;
  logic        valid;
  logic        ready;
  logic        packet_valid;
  logic [63:0] packet_low;
  logic [63:0] packet_high;
  logic [1:0]  frame_event;
  logic [3:0]  fifo_count;
  logic [1:0]  fifo_status;

  modport source (output valid, output packet_valid, output packet_low,
                  output packet_high, output frame_event, output fifo_count,
                  output fifo_status, input ready);
  modport sink   (input valid, input packet_valid, input packet_low,
                  input packet_high, input frame_event, input fifo_count,
                  input fifo_status, output ready);
endinterface

// ===== rtl/fixed_frame_receiver_with_fifo.sv =====
// Top level: fixed 16-byte frame receiver feeding a packet FIFO.
//
//  channel  | dir | payload                                      | handshake
//  ---------+-----+----------------------------------------------+-------------
//  in_ch    | in  | action, rx_byte                              | valid/ready
//  out_ch   | out | packet_valid, packet_low/high, frame_event,  | valid/ready
//           |     | fifo_count, fifo_status                      |
//  cfg_*    | in  | cfg_idx, cfg_wdata                           | cfg_we only
//
// One result per input transfer, in the cycle after acceptance; a transfer
// can be taken every cycle while no result is held or out_ch.ready is high.
// The result register and the FIFO's registered read port form one stage.
// in_ch.ready is low only while a result is held and out_ch.ready is low.
// Synchronous active-low reset clears frame position, FIFO pointers, count,
// delimiters (to '*' and '#') and the result valid; no clearing pass.
module fixed_frame_receiver_with_fifo #(
  parameter int FIFO_DEPTH = ffrf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ffrf_in_if.sink                         in_ch,
  ffrf_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ffrf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ffrf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ffrf_pkg::*;

`include "fixed_frame_receiver_with_fifo_macros.svh"

  // Delimiter registers
  logic [CFG_DATA_W-1:0] start_delim_r, end_delim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delim_r <= START_DELIM_RST;
      end_delim_r   <= END_DELIM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START_DELIM: start_delim_r <= cfg_wdata;
        REG_END_DELIM:   end_delim_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result register state, declared here as the input side reads its valid.
  logic                   out_vld_r;
  logic                   pkt_vld_r;
  frame_event_t           ev_r;
  logic [COUNT_OUT_W-1:0] cnt_r;
  fifo_status_t           status_r;

  // Input transfer: taken whenever the result register is free or draining.
  logic in_ready, in_xfer, rx_en, pop_req;

  assign in_ready    = !out_vld_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign in_xfer     = in_ch.valid && in_ready;
  assign rx_en       = in_xfer && (in_ch.action == ACT_RX);
  assign pop_req     = in_xfer && (in_ch.action == ACT_POP);

  frame_stat_t fstat;
  fifo_stat_t  qstat;
  logic [63:0] frame_lo, frame_hi, rd_lo, rd_hi;

  ffrf_assembler u_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (rx_en),
    .rx_byte     (in_ch.rx_byte),
    .start_delim (start_delim_r),
    .end_delim   (end_delim_r),
    .stat        (fstat),
    .frame_lo    (frame_lo),
    .frame_hi    (frame_hi)
  );

  ffrf_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (fstat.done && fstat.ok),
    .pop_req  (pop_req),
    .wr_lo    (frame_lo),
    .wr_hi    (frame_hi),
    .rd_lo    (rd_lo),
    .rd_hi    (rd_hi),
    .stat     (qstat)
  );

  // Frame event for this transfer; a full FIFO drops a good frame.
  frame_event_t ev;

  always_comb begin
    ev = EV_NONE;
    if (fstat.done) begin
      if (!fstat.ok) begin
        ev = EV_BAD;
      end else if (qstat.full) begin
        ev = EV_DROPPED;
      end else begin
        ev = EV_STORED;
      end
    end
  end

  // Result register. Packet data sits in the FIFO read register, which only
  // moves on a successful pop, so it stays put while the result is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_xfer) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pkt_vld_r <= pop_req && !qstat.empty;
      ev_r      <= ev;
      cnt_r     <= qstat.count_nxt;
      status_r  <= qstat.status_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.packet_valid = pkt_vld_r;
  assign out_ch.packet_low   = pkt_vld_r ? rd_lo : '0;
  assign out_ch.packet_high  = pkt_vld_r ? rd_hi : '0;
  assign out_ch.frame_event  = ev_r;
  assign out_ch.fifo_count   = cnt_r;
  assign out_ch.fifo_status  = status_r;

  // Checks
  `FFRF_ASSERT_SAME(a_pop_no_event, clk, rst_n, out_vld_r && pkt_vld_r, ev_r == EV_NONE, "pop result carries a frame event")
  `FFRF_ASSERT_SAME(a_empty_count, clk, rst_n, out_vld_r && status_r == ST_EMPTY, cnt_r == '0, "empty status with non-zero count")
  `FFRF_ASSERT_NEXT(a_pop_returns, clk, rst_n, pop_req && !qstat.empty, out_vld_r && pkt_vld_r, "pop on non-empty FIFO returned no packet")
  `FFRF_ASSERT_SAME(a_drop_when_full, clk, rst_n, out_vld_r && ev_r == EV_DROPPED, status_r == ST_FULL, "frame dropped while FIFO not full")

endmodule

// ===== rtl/ffrf_assembler.sv =====
// Frame assembly: byte position, held bytes and delimiter check.
module ffrf_assembler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [7:0]                       rx_byte,
  input  logic [ffrf_pkg::CFG_DATA_W-1:0]  start_delim,
  input  logic [ffrf_pkg::CFG_DATA_W-1:0]  end_delim,
  output ffrf_pkg::frame_stat_t            stat,
  output logic [63:0]                      frame_lo,
  output logic [63:0]                      frame_hi
);
  import ffrf_pkg::*;

  localparam int POS_W = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  // last byte is never stored, it arrives with the check
  logic [7:0]       bytes_r [FRAME_LEN-1];
  logic             last;

  assign last = (pos_r == LAST_POS);

  always_comb begin
    pos_nxt = pos_r;
    if (en) begin
      pos_nxt = last ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      if (en && pos_r == POS_W'(i)) begin
        bytes_r[i] <= rx_byte;
      end
    end
  end

  assign stat.done = en && last;
  assign stat.ok   = (bytes_r[0] == start_delim) && (rx_byte == end_delim);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      frame_lo[8*i +: 8] = bytes_r[i];
    end
    for (int i = 0; i < 7; i++) begin
      frame_hi[8*i +: 8] = bytes_r[8 + i];
    end
    frame_hi[63:56] = rx_byte;
  end

endmodule

// ===== rtl/ffrf_fifo.sv =====
// Circular packet store with registered read port and occupancy tracking.
module ffrf_fifo #(
  parameter int FIFO_DEPTH = ffrf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_req,
  input  logic                 pop_req,
  input  logic [63:0]          wr_lo,
  input  logic [63:0]          wr_hi,
  output logic [63:0]          rd_lo,
  output logic [63:0]          rd_hi,
  output ffrf_pkg::fifo_stat_t stat
);
  import ffrf_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FIFO_DEPTH);

  logic [127:0]     mem [FIFO_DEPTH];
  logic [127:0]     rd_r;
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full, empty, push, pop;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign push  = push_req && !full;
  assign pop   = pop_req && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_SLOT) ? '0 : wptr_r + 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_SLOT) ? '0 : rptr_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= {wr_hi, wr_lo};
    end
    if (pop) begin
      rd_r <= mem[rptr_r];
    end
  end

  assign rd_lo = rd_r[63:0];
  assign rd_hi = rd_r[127:64];

  always_comb begin
    stat.full      = full;
    stat.empty     = empty;
    stat.count_nxt = COUNT_OUT_W'(cnt_nxt);
    if (cnt_nxt == '0) begin
      stat.status_nxt = ST_EMPTY;
    end else if (cnt_nxt == CNT_FULL) begin
      stat.status_nxt = ST_FULL;
    end else begin
      stat.status_nxt = ST_OK;
    end
  end

endmodule
